FILE: design/mtr_pkg.sv
`timescale 1ns / 1ps

package mtr_pkg;

    // Ring geometry.
    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END   = 1'd1;

    // Reset values of the window registers.
    localparam logic [31:0] WINDOW_START_RST = 32'h0000_0000;
    localparam logic [31:0] WINDOW_END_RST   = 32'hFFFF_FFFF;

    // Command codes. The reserved code is ignored by the block.
    localparam logic [1:0] CMD_RECORD_READ  = 2'd0;
    localparam logic [1:0] CMD_RECORD_WRITE = 2'd1;
    localparam logic [1:0] CMD_DUMP         = 2'd2;
    localparam logic [1:0] CMD_RESERVED     = 2'd3;

    // Input word.
    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] pc;
        logic [31:0] addr;
        logic [31:0] data;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic [31:0] entry_pc;
        logic [31:0] entry_addr;
        logic [31:0] entry_data;
        logic        is_write;
        logic        last;
    } t_out_word;

    // One slot of the ring as held in memory.
    typedef struct packed {
        logic [31:0] pc;
        logic [31:0] addr;
        logic [31:0] data;
        logic        is_write;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Dump sequencer states.
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } t_state;

endpackage

FILE: design/mtr_ram.sv
`timescale 1ns / 1ps

module mtr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/memory_access_trace_ring_core.sv
`timescale 1ns / 1ps

// Memory-access trace ring. A record word (read or write access) is taken in
// any cycle in which busy is low and finishes in that same cycle, so records can
// arrive back to back; it is stored only when its address lies inside the
// inclusive window. A dump word with n stored entries (n up to DEPTH) holds busy
// high while the sequencer reads one slot per cycle from the single read port
// of the ring memory; each result follows in the cycle after its read, one per
// cycle, oldest first, with last set on the final one. A dump of an empty ring
// produces nothing and leaves busy low. The receiver cannot stall: each result
// word is valid on o_res_word only in the cycle in which
// o_res_valid is high. The ring needs no clearing pass after reset, since a
// fill count tells which slots hold entries.
module memory_access_trace_ring_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  mtr_pkg::t_in_word             i_in_word,
    output logic                          o_res_valid,
    output mtr_pkg::t_out_word            o_res_word,
    input  logic                          i_cfg_we,
    input  logic [mtr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mtr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import mtr_pkg::*;

    logic [31:0]       r_win_start;
    logic [31:0]       r_win_end;
    logic [ADDR_W-1:0] r_wp;
    logic [ADDR_W-1:0] n_wp;
    logic              r_full;
    logic              n_full;
    t_state            r_state;
    t_state            n_state;
    logic [ADDR_W-1:0] r_rd_ptr;
    logic [ADDR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0]  r_rd_left;
    logic [CNT_W-1:0]  n_rd_left;
    logic              r_out_vld;
    logic              r_out_last;

    logic              accept;
    logic              is_record;
    logic              in_window;
    logic              ram_we;
    logic              ram_re;
    logic [CNT_W-1:0]  fill_count;
    t_entry            wr_entry;
    t_entry            rd_entry;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_start <= WINDOW_START_RST;
            r_win_end   <= WINDOW_END_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WINDOW_START: r_win_start <= i_cfg_data;
                REG_WINDOW_END:   r_win_end   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Word acceptance and capture decision.
    assign accept    = start && !busy;
    assign is_record = (i_in_word.command == CMD_RECORD_READ) ||
                       (i_in_word.command == CMD_RECORD_WRITE);
    assign in_window = (i_in_word.addr >= r_win_start) && (i_in_word.addr <= r_win_end);
    assign ram_we    = accept && is_record && in_window;
    assign fill_count = r_full ? CNT_W'(DEPTH) : CNT_W'(r_wp);

    assign wr_entry.pc       = i_in_word.pc;
    assign wr_entry.addr     = i_in_word.addr;
    assign wr_entry.data     = i_in_word.data;
    assign wr_entry.is_write = (i_in_word.command == CMD_RECORD_WRITE);

    // Write position and fill state advance on each capture.
    always_comb begin
        n_wp   = r_wp;
        n_full = r_full;
        if (ram_we) begin
            if (r_wp == ADDR_W'(DEPTH - 1)) begin
                n_wp   = '0;
                n_full = 1'b1;
            end else begin
                n_wp = r_wp + 1'b1;
            end
        end
    end

    // Dump sequencer: one slot read per cycle, oldest slot first.
    assign ram_re = (r_state == S_DUMP);

    always_comb begin
        n_state   = r_state;
        n_rd_ptr  = r_rd_ptr;
        n_rd_left = r_rd_left;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_in_word.command == CMD_DUMP) && (fill_count != '0)) begin
                    n_state   = S_DUMP;
                    n_rd_ptr  = r_full ? r_wp : '0;
                    n_rd_left = fill_count;
                end
            end
            S_DUMP: begin
                n_rd_ptr  = (r_rd_ptr == ADDR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
                n_rd_left = r_rd_left - 1'b1;
                if (r_rd_left == CNT_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp       <= '0;
            r_full     <= 1'b0;
            r_state    <= S_IDLE;
            r_rd_ptr   <= '0;
            r_rd_left  <= '0;
            r_out_vld  <= 1'b0;
            r_out_last <= 1'b0;
        end else begin
            r_wp       <= n_wp;
            r_full     <= n_full;
            r_state    <= n_state;
            r_rd_ptr   <= n_rd_ptr;
            r_rd_left  <= n_rd_left;
            r_out_vld  <= ram_re;
            r_out_last <= ram_re && (r_rd_left == CNT_W'(1));
        end
    end

    // Ring memory.
    mtr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (wr_entry),
        .i_re    (ram_re),
        .i_raddr (r_rd_ptr),
        .o_rdata (rd_entry)
    );

    // Result word comes straight from the registered read data.
    assign busy                  = (r_state == S_DUMP);
    assign o_res_valid           = r_out_vld;
    assign o_res_word.entry_pc   = rd_entry.pc;
    assign o_res_word.entry_addr = rd_entry.addr;
    assign o_res_word.entry_data = rd_entry.data;
    assign o_res_word.is_write   = rd_entry.is_write;
    assign o_res_word.last       = r_out_last;

    // A dump in progress always has reads left to issue.
    a_dump_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP) |-> (r_rd_left != '0))
        else $error("dump active with no reads left");

    // No capture may write the ring while a dump reads it.
    a_no_write_in_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP) |-> !ram_we)
        else $error("ring written during dump");

    // The final read ends the dump and flags the last result.
    a_last_ends_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DUMP) && (r_rd_left == CNT_W'(1))) |=>
        (o_res_valid && o_res_word.last && (r_state == S_IDLE)))
        else $error("dump did not end with a last result");

    // Results only follow cycles of the dump sequencer.
    a_result_from_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(r_state == S_DUMP))
        else $error("result outside a dump");

endmodule
